// File: design/kt2d_pkg.sv
// Package for the 2-D constant-velocity Kalman tracker.
// Holds Q16.16 arithmetic helpers, datapath opcodes and controller state types.
// No dependencies.
`default_nettype none
package kt2d_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam logic signed [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = DW'(1) << FB;

  // register addresses (byte address / 4)
  localparam logic [1:0] REG_PNOISE = 2'd0;
  localparam logic [1:0] REG_MNOISE = 2'd1;
  localparam logic [1:0] REG_IVAR   = 2'd2;

  // shared multiplier modes
  localparam logic [1:0] MODE_DET  = 2'd0;
  localparam logic [1:0] MODE_GAIN = 2'd1;
  localparam logic [1:0] MODE_UPD  = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_DET,
    ST_DIV,
    ST_GAIN,
    ST_UPD,
    ST_OUT
  } state_e;

  // datapath commands from controller
  typedef struct packed {
    logic       load;     // capture input beat, do restart, predict
    logic       det_go;   // run determinant products
    logic       div_go;   // start one division
    logic [1:0] div_idx;
    logic       gain_go;  // compute gain entries
    logic       upd_go;   // compute update
    logic       commit;   // write back state and covariance
  } cmd_t;

  typedef struct packed {
    logic sing;
    logic div_busy;
    logic mac_done;
  } stat_t;

  function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] v);
    if (v > (DW+2)'(VMAX)) return VMAX;
    if (v < (DW+2)'(VMIN)) return VMIN;
    return v[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] sadd(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return sat((DW+2)'(a) + (DW+2)'(b));
  endfunction

  function automatic logic signed [DW-1:0] ssub(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    return sat((DW+2)'(a) - (DW+2)'(b));
  endfunction

  function automatic logic signed [DW-1:0] sneg(input logic signed [DW-1:0] a);
    return (a == VMIN) ? VMAX : -a;
  endfunction

  // floor shift then saturate of a full product
  function automatic logic signed [DW-1:0] mscale(input logic signed [2*DW-1:0] p);
    logic signed [2*DW-1:0] s;
    s = p >>> FB;
    if (s > (2*DW)'(VMAX)) return VMAX;
    if (s < (2*DW)'(VMIN)) return VMIN;
    return s[DW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: design/kt2d_div.sv
// Radix-2 restoring divider: a*2^FB / b, truncated toward zero, saturated.
// Depends on kt2d_pkg.
`default_nettype none
module kt2d_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic signed [kt2d_pkg::DW-1:0] num_i,
  input  wire logic signed [kt2d_pkg::DW-1:0] den_i,
  output logic                             busy_o,
  output logic signed [kt2d_pkg::DW-1:0]   quo_o
);
  import kt2d_pkg::*;
  localparam int NW = DW + FB;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW:0]   trial;
  logic [DW-1:0] ma, mb;

  always_comb begin
    ma = num_i[DW-1] ? DW'(-num_i) : num_i;
    mb = den_i[DW-1] ? DW'(-den_i) : den_i;
    num_d = num_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    neg_d = neg_q; cnt_d = cnt_q;
    trial = {rem_q[DW-1:0], num_q[NW-1]};
    if (start_i) begin
      num_d = {ma, {FB{1'b0}}};
      den_d = mb;
      rem_d = '0;
      quo_d = '0;
      neg_d = num_i[DW-1] ^ den_i[DW-1];
      cnt_d = CW'(NW);
    end else if (cnt_q != '0) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign busy_o = start_i || (cnt_q != '0);

  always_comb begin
    if (!neg_q) begin
      quo_o = (quo_q > NW'(VMAX)) ? VMAX : quo_q[DW-1:0];
    end else begin
      quo_o = (quo_q >= NW'(VMAX) + NW'(1)) ? VMIN : -quo_q[DW-1:0];
    end
  end
endmodule
`default_nettype wire

// File: design/kt2d_datapath.sv
// Datapath: state, covariance, one shared multiplier, and the divider.
// Depends on kt2d_pkg and kt2d_div.
`default_nettype none
module kt2d_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire kt2d_pkg::cmd_t        cmd_i,
  output kt2d_pkg::stat_t            stat_o,
  input  wire logic [64:0]           in_i,
  input  wire logic [30:0]           pnoise_i,
  input  wire logic [30:0]           mnoise_i,
  input  wire logic [30:0]           ivar_i,
  output logic [256:0]               res_o
);
  import kt2d_pkg::*;

  logic signed [DW-1:0] x_q [4];
  logic signed [DW-1:0] p_q [16];
  logic signed [DW-1:0] xp_q [4];
  logic signed [DW-1:0] pp_q [16];
  logic signed [DW-1:0] y_q [2];
  logic signed [DW-1:0] s_q [4];
  logic signed [DW-1:0] det_q;
  logic signed [DW-1:0] si_q [4];
  logic signed [DW-1:0] k_q [8];
  logic signed [DW-1:0] xn_q [4];
  logic signed [DW-1:0] pn_q [16];
  logic                 sing;

  // MAC sequencer: each op is sadd/ssub of two products; update state ops add one product into xn
  logic [5:0] op_q;          // operation index
  logic       ph_q;          // product phase
  logic       busy_q;
  logic [1:0] mode_q;        // MODE_DET, MODE_GAIN or MODE_UPD
  logic signed [DW-1:0] ma, mb, pr0_q;
  logic signed [2*DW-1:0] prod_q;
  logic       pv_q;
  logic [5:0] nops;
  logic signed [DW-1:0] prm;

  logic signed [DW-1:0] dnum, dquo;
  logic       dbusy;

  logic signed [DW-1:0] rv, qv;
  logic signed [DW-1:0] m [16];
  logic signed [DW-1:0] pp [16];
  logic signed [DW-1:0] z0, z1;
  logic signed [DW-1:0] x0 [4];
  logic signed [DW-1:0] p0 [16];

  assign qv = DW'({1'b0, pnoise_i});
  assign rv = DW'({1'b0, mnoise_i});

  // operand selection for (mode, op, phase)
  always_comb begin
    logic [3:0] cidx;
    ma = '0; mb = '0;
    nops = 6'd1;
    cidx = 4'(op_q - 6'd8);
    case (mode_q)
      MODE_DET: begin
        nops = 6'd1;
        ma = ph_q ? s_q[1] : s_q[0];
        mb = ph_q ? s_q[2] : s_q[3];
      end
      MODE_GAIN: begin
        // op = i*2+j ; k[i][j] = pp[i][0]*si[0][j] + pp[i][1]*si[1][j]
        nops = 6'd8;
        ma = pp_q[{op_q[2:1], 1'b0, ph_q}];
        mb = si_q[{ph_q, op_q[0]}];
      end
      MODE_UPD: begin
        // op 0..7: state, op = i*2+t ; op 8..23: cov op-8 = i*4+j
        nops = 6'd24;
        if (op_q < 6'd8) begin
          ma = k_q[{op_q[2:1], op_q[0]}];
          mb = y_q[op_q[0]];
        end else begin
          ma = k_q[{cidx[3:2], ph_q}];
          mb = pp_q[{1'b0, ph_q, cidx[1:0]}];
        end
      end
      default: ;
    endcase
  end

  assign prm = mscale(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; pv_q <= 1'b0; op_q <= '0; ph_q <= 1'b0; mode_q <= MODE_DET;
    end else begin
      pv_q <= busy_q && !pv_q;
      if (cmd_i.det_go || cmd_i.gain_go || cmd_i.upd_go) begin
        busy_q <= 1'b1; op_q <= '0; ph_q <= 1'b0;
        mode_q <= cmd_i.det_go ? MODE_DET : (cmd_i.gain_go ? MODE_GAIN : MODE_UPD);
      end else if (busy_q && pv_q) begin
        // product registered, consume it
        if (mode_q == MODE_UPD && op_q < 6'd8) begin
          op_q <= op_q + 6'd1;
          ph_q <= 1'b0;
        end else if (ph_q) begin
          ph_q <= 1'b0;
          if (op_q == nops - 6'd1) busy_q <= 1'b0;
          else op_q <= op_q + 6'd1;
        end else begin
          ph_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !pv_q) prod_q <= ma * mb;
  end

  // result accumulation
  always_ff @(posedge clk_i) begin
    if (busy_q && pv_q) begin
      case (mode_q)
        MODE_DET: begin
          if (!ph_q) pr0_q <= prm;
          else det_q <= ssub(pr0_q, prm);
        end
        MODE_GAIN: begin
          if (!ph_q) pr0_q <= prm;
          else k_q[op_q[2:0]] <= sadd(pr0_q, prm);
        end
        MODE_UPD: begin
          if (op_q < 6'd8) begin
            xn_q[op_q[2:1]] <= sadd(xn_q[op_q[2:1]], prm);
          end else if (!ph_q) begin
            pr0_q <= prm;
          end else begin
            pn_q[4'(op_q - 6'd8)] <= ssub(pp_q[4'(op_q - 6'd8)], sadd(pr0_q, prm));
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.upd_go) begin
      for (int i = 0; i < 4; i++) xn_q[i] <= xp_q[i];
    end
  end

  // divider
  always_comb begin
    case (cmd_i.div_idx)
      2'd0: dnum = s_q[3];
      2'd1: dnum = sneg(s_q[1]);
      2'd2: dnum = sneg(s_q[2]);
      default: dnum = s_q[0];
    endcase
  end

  kt2d_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_go),
    .num_i  (dnum),
    .den_i  (det_q),
    .busy_o (dbusy),
    .quo_o  (dquo)
  );

  logic [1:0] dsel_q;
  logic       dpend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpend_q <= 1'b0; dsel_q <= '0;
    end else begin
      if (cmd_i.div_go) begin
        dpend_q <= 1'b1; dsel_q <= cmd_i.div_idx;
      end else if (dpend_q && !dbusy) begin
        dpend_q <= 1'b0;
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (dpend_q && !dbusy && !cmd_i.div_go) si_q[dsel_q] <= dquo;
  end

  // predict (additions only)
  always_comb begin
    z0 = in_i[31:0];
    z1 = in_i[63:32];
    for (int i = 0; i < 4; i++) x0[i] = in_i[64] ? '0 : x_q[i];
    for (int i = 0; i < 16; i++) begin
      if (in_i[64]) p0[i] = (i % 5 == 0) ? DW'({1'b0, ivar_i}) : '0;
      else p0[i] = p_q[i];
    end
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m[i*4+j] = (i < 2) ? sadd(p0[i*4+j], p0[(i+2)*4+j]) : p0[i*4+j];
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        pp[i*4+j] = (j < 2) ? sadd(m[i*4+j], m[i*4+j+2]) : m[i*4+j];
        if (i == j) pp[i*4+j] = sadd(pp[i*4+j], qv);
      end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xp_q[0] <= sadd(x0[0], x0[2]);
      xp_q[1] <= sadd(x0[1], x0[3]);
      xp_q[2] <= x0[2];
      xp_q[3] <= x0[3];
      for (int i = 0; i < 16; i++) pp_q[i] <= pp[i];
      y_q[0] <= ssub(z0, sadd(x0[0], x0[2]));
      y_q[1] <= ssub(z1, sadd(x0[1], x0[3]));
      s_q[0] <= sadd(pp[0], rv);
      s_q[1] <= pp[1];
      s_q[2] <= pp[4];
      s_q[3] <= sadd(pp[5], rv);
    end
  end

  assign sing = (det_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) x_q[i] <= '0;
      for (int i = 0; i < 16; i++) p_q[i] <= (i % 5 == 0) ? ONE : '0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < 4; i++) x_q[i] <= sing ? xp_q[i] : xn_q[i];
      for (int i = 0; i < 16; i++) p_q[i] <= sing ? pp_q[i] : pn_q[i];
    end
  end

  assign stat_o = '{sing:     sing,
                    div_busy: dpend_q || cmd_i.div_go,
                    mac_done: !busy_q && !(cmd_i.det_go || cmd_i.gain_go || cmd_i.upd_go)};

  assign res_o = {sing,
                  p_q[15], p_q[10], p_q[5], p_q[0],
                  x_q[3], x_q[2], x_q[1], x_q[0]};
endmodule
`default_nettype wire

// File: design/kt2d_ctrl.sv
// Step sequencer: predict, determinant, four divisions, gain, update, output; a singular determinant goes to output.
// Depends on kt2d_pkg.
`default_nettype none
module kt2d_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_fire_i,
  input  wire logic            out_fire_i,
  input  wire kt2d_pkg::stat_t stat_i,
  output kt2d_pkg::cmd_t       cmd_o,
  output logic                 in_ready_o,
  output logic                 out_valid_o
);
  import kt2d_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] dix_q, dix_d;
  logic       go_q, go_d;

  always_comb begin
    state_d = state_q; dix_d = dix_q; go_d = 1'b0;
    case (state_q)
      ST_IDLE: if (in_fire_i) state_d = ST_PRED;
      ST_PRED: begin state_d = ST_DET; go_d = 1'b1; end
      ST_DET: if (!go_q && stat_i.mac_done) begin
        if (stat_i.sing) state_d = ST_OUT;
        else begin state_d = ST_DIV; dix_d = '0; go_d = 1'b1; end
      end
      ST_DIV: if (!go_q && !stat_i.div_busy) begin
        go_d = 1'b1;
        if (dix_q == 2'd3) state_d = ST_GAIN;
        else dix_d = dix_q + 2'd1;
      end
      ST_GAIN: if (!go_q && stat_i.mac_done) begin state_d = ST_UPD; go_d = 1'b1; end
      ST_UPD: if (!go_q && stat_i.mac_done) state_d = ST_OUT;
      ST_OUT: if (out_fire_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; dix_q <= '0; go_q <= 1'b0;
    end else begin
      state_q <= state_d; dix_q <= dix_d; go_q <= go_d;
    end
  end

  logic commit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) commit_q <= 1'b0;
    else commit_q <= (state_q != ST_OUT) && (state_d == ST_OUT);
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.load    = in_fire_i;
    cmd_o.det_go  = (state_q == ST_DET) && go_q;
    cmd_o.div_go  = (state_q == ST_DIV) && go_q;
    cmd_o.div_idx = dix_q;
    cmd_o.gain_go = (state_q == ST_GAIN) && go_q;
    cmd_o.upd_go  = (state_q == ST_UPD) && go_q;
    cmd_o.commit  = (state_q != ST_OUT) && (state_d == ST_OUT);
    in_ready_o    = (state_q == ST_IDLE);
    out_valid_o   = (state_q == ST_OUT) && !commit_q;
  end
endmodule
`default_nettype wire

// File: design/kalman_tracker_2d_const_velocity_top.sv
// 2-D constant-velocity Kalman tracker, top level.
// The result follows the input beat after predict, determinant, four serial divides,
// gain and update; determinant, gain and update share one 32x32 multiplier, and one
// output bubble precedes the result. A singular step skips divides, gain and update.
// One item at a time; next input beat taken the cycle after the result beat leaves.
// Async active-low reset: state zero, covariance identity, registers at defaults.
`default_nettype none
module kalman_tracker_2d_const_velocity_top (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [63:0]  s_axis_tdata_i,   // meas_x[31:0], meas_y[63:32]
  input  wire logic         s_axis_tuser_i,   // restart
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [255:0]      m_axis_tdata_o,   // est_pos_x,y, est_vel_x,y, var x,y,vx,vy
  output logic              m_axis_tuser_o,   // singular
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import kt2d_pkg::*;

  logic [30:0] pn_q, mn_q, iv_q;
  cmd_t  cmd;
  stat_t stat;
  logic  in_fire, out_fire;
  logic [256:0] res;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q <= 31'd6554; mn_q <= 31'd6554; iv_q <= 31'd65536;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_PNOISE: pn_q <= pwdata[30:0];
        REG_MNOISE: mn_q <= pwdata[30:0];
        REG_IVAR:   iv_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_PNOISE: prdata = {1'b0, pn_q};
      REG_MNOISE: prdata = {1'b0, mn_q};
      REG_IVAR:   prdata = {1'b0, iv_q};
      default:    prdata = '0;
    endcase
  end

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  kt2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_fire_i(out_fire),
    .stat_i(stat), .cmd_o(cmd),
    .in_ready_o(s_axis_tready_o), .out_valid_o(m_axis_tvalid_o)
  );

  kt2d_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .in_i({s_axis_tuser_i, s_axis_tdata_i}),
    .pnoise_i(pn_q), .mnoise_i(mn_q), .ivar_i(iv_q), .res_o(res)
  );

  assign m_axis_tdata_o = res[255:0];
  assign m_axis_tuser_o = res[256];

  // no new beat while a result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o) else $error("accept during output");
  // accept leads to busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready_o) else $error("ready after accept");
endmodule
`default_nettype wire
